/* hdl/three_plane_intersection_core_assert.svh */
// Assertion macros for the three-plane intersection core.
// Used by the top level only; empty when SYNTHESIS is defined.
`ifndef THREE_PLANE_INTERSECTION_CORE_ASSERT_SVH
`define THREE_PLANE_INTERSECTION_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TPI_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define TPI_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed");
`else
`define TPI_ASSERT_ALWAYS(label, clk, rst, expr)
`define TPI_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif
`endif

/* hdl/tpi_pkg.sv */
// Shared types, widths and the divider step for the three-plane intersection core.
// No dependencies.
`default_nettype none
package tpi_pkg;
  localparam int COEF_WIDTH    = 16;
  localparam int OUT_FRAC_BITS = 16;
  localparam int OUT_WIDTH     = 32;
  localparam int PROD_W        = 2 * COEF_WIDTH;
  localparam int MINOR_W       = PROD_W + 1;
  localparam int TERM_W        = MINOR_W + COEF_WIDTH;
  localparam int DET_W         = TERM_W + 2;
  localparam int REM_W         = DET_W + 1;
  localparam int SHIFT_IN      = OUT_WIDTH - OUT_FRAC_BITS;
  localparam int DET_LAT       = 4;
  localparam int DIV_STEPS     = OUT_WIDTH;
  localparam int DIV_LAT       = DIV_STEPS + 2;
  localparam int TOT_LAT       = DET_LAT + DIV_LAT;

  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [MINOR_W-1:0]    minor_t;
  typedef logic signed [TERM_W-1:0]     term_t;
  typedef logic signed [DET_W-1:0]      det_t;

  typedef struct packed {
    coef_t w;
    coef_t z;
    coef_t y;
    coef_t x;
  } plane_t;

  typedef struct packed {
    logic [REM_W-1:0]     rem;
    logic [OUT_WIDTH-1:0] quo;
    logic [OUT_WIDTH-1:0] bits;
    logic [DET_W-1:0]     dmag;
    logic                 neg;
    logic                 ov;
  } div_stage_t;

  // One restoring step: bring in the next numerator bit, subtract if it fits.
  function automatic div_stage_t div_step(div_stage_t s);
    div_stage_t       o;
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] dd;
    o  = s;
    r2 = {s.rem[REM_W-2:0], s.bits[OUT_WIDTH-1]};
    dd = REM_W'(s.dmag);
    o.bits = {s.bits[OUT_WIDTH-2:0], 1'b0};
    if (r2 >= dd) begin
      o.rem = r2 - dd;
      o.quo = {s.quo[OUT_WIDTH-2:0], 1'b1};
    end else begin
      o.rem = r2;
      o.quo = {s.quo[OUT_WIDTH-2:0], 1'b0};
    end
    return o;
  endfunction
endpackage
`default_nettype wire

/* hdl/three_plane_intersection_core.sv */
// Three-plane intersection core: throughput one word per cycle while the skid register
// is empty (4 determinant stages, 34 divider stages, one quotient bit per step stage,
// then the output register). A skid register catches the word leaving the pipeline
// when the output stalls; input then stalls until the skid register drains.
// Synchronous active-high rst clears all valid bits; payload registers are not reset.
// Depends on tpi_pkg, tpi_det, tpi_div and three_plane_intersection_core_assert.svh.
`default_nettype none
`include "three_plane_intersection_core_assert.svh"
module three_plane_intersection_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // a_normal_x, a_normal_y, a_normal_z, a_offset, b_*, c_* (16 bits each, low first)
  input  wire logic [191:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // found, saturated, point_x[31:0], point_y[31:0], point_z[31:0], zero pad
  output logic [103:0]      m_tdata
);
  localparam int OW = tpi_pkg::OUT_WIDTH;
  localparam int WW = 2 + 3 * OW;

  tpi_pkg::plane_t a, b, c;
  tpi_pkg::det_t   den, num_x, num_y, num_z;
  logic [OW-1:0]   cx, cy, cz;
  logic            ox, oy, oz;
  logic            en;
  logic [tpi_pkg::TOT_LAT-1:0] vld;
  logic [tpi_pkg::DIV_LAT-1:0] fnd;
  logic [WW-1:0]   word, skid;
  logic            skid_v;
  logic            push;
  logic            f_out;

  assign a = {s_tdata[63:48],   s_tdata[47:32],   s_tdata[31:16],   s_tdata[15:0]};
  assign b = {s_tdata[127:112], s_tdata[111:96],  s_tdata[95:80],   s_tdata[79:64]};
  assign c = {s_tdata[191:176], s_tdata[175:160], s_tdata[159:144], s_tdata[143:128]};

  assign en       = !skid_v;
  assign s_tready = en;

  tpi_det u_det (
    .clk(clk), .en(en), .a(a), .b(b), .c(c),
    .den(den), .num_x(num_x), .num_y(num_y), .num_z(num_z)
  );

  tpi_div u_div_x (.clk(clk), .en(en), .num(num_x), .den(den), .coord(cx), .over(ox));
  tpi_div u_div_y (.clk(clk), .en(en), .num(num_y), .den(den), .coord(cy), .over(oy));
  tpi_div u_div_z (.clk(clk), .en(en), .num(num_z), .den(den), .coord(cz), .over(oz));

  // Carry valid bits with the data, and the nonsingular flag alongside the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[tpi_pkg::TOT_LAT-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fnd <= {fnd[tpi_pkg::DIV_LAT-2:0], den != '0};
    end
  end

  // Assemble the result word; zero everything for singular normals
  always_comb begin
    f_out = fnd[tpi_pkg::DIV_LAT-1];
    word  = f_out ? {cz, cy, cx, (ox | oy | oz), 1'b1} : '0;
    push  = en && vld[tpi_pkg::TOT_LAT-1];
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_v   <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_v) begin
        m_tvalid <= 1'b1;
        skid_v   <= 1'b0;
      end else begin
        m_tvalid <= push;
      end
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      m_tdata <= {{(104-WW){1'b0}}, (skid_v ? skid : word)};
    end else if (push) begin
      skid <= word;
    end
  end

  `TPI_ASSERT_ALWAYS(a_skid_implies_out, clk, rst, !skid_v || m_tvalid)
  `TPI_ASSERT_NEXT(a_hold_out, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `TPI_ASSERT_ALWAYS(a_not_found_zero, clk, rst,
    !m_tvalid || m_tdata[0] || (m_tdata[103:1] == '0))
  `TPI_ASSERT_NEXT(a_skid_blocks, clk, rst, skid_v && !m_tready, !s_tready)
endmodule
`default_nettype wire

/* hdl/tpi_det.sv */
// Four-stage determinant pipeline: denominator and the three Cramer numerators.
// Depends on tpi_pkg.
`default_nettype none
module tpi_det (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire tpi_pkg::plane_t a,
  input  wire tpi_pkg::plane_t b,
  input  wire tpi_pkg::plane_t c,
  output tpi_pkg::det_t       den,
  output tpi_pkg::det_t       num_x,
  output tpi_pkg::det_t       num_y,
  output tpi_pkg::det_t       num_z
);
  // minor order: yz, xz, xy, xw, yw, zw
  tpi_pkg::prod_t  p_lo [6];
  tpi_pkg::prod_t  p_hi [6];
  tpi_pkg::minor_t m [6];
  tpi_pkg::term_t  t [12];
  tpi_pkg::plane_t a1, a2;

  // Stage 1: cross products of rows b and c
  always_ff @(posedge clk) begin
    if (en) begin
      p_lo[0] <= b.y * c.z;  p_hi[0] <= b.z * c.y;
      p_lo[1] <= b.x * c.z;  p_hi[1] <= b.z * c.x;
      p_lo[2] <= b.x * c.y;  p_hi[2] <= b.y * c.x;
      p_lo[3] <= b.x * c.w;  p_hi[3] <= b.w * c.x;
      p_lo[4] <= b.y * c.w;  p_hi[4] <= b.w * c.y;
      p_lo[5] <= b.z * c.w;  p_hi[5] <= b.w * c.z;
      a1 <= a;
    end
  end

  // Stage 2: 2x2 minors
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        m[i] <= tpi_pkg::minor_t'(p_lo[i]) - tpi_pkg::minor_t'(p_hi[i]);
      end
      a2 <= a1;
    end
  end

  // Stage 3: row a times minors
  always_ff @(posedge clk) begin
    if (en) begin
      t[0]  <= a2.x * m[0];  t[1]  <= a2.y * m[1];  t[2]  <= a2.z * m[2];
      t[3]  <= a2.w * m[0];  t[4]  <= a2.y * m[5];  t[5]  <= a2.z * m[4];
      t[6]  <= a2.x * m[5];  t[7]  <= a2.w * m[1];  t[8]  <= a2.z * m[3];
      t[9]  <= a2.x * m[4];  t[10] <= a2.y * m[3];  t[11] <= a2.w * m[2];
    end
  end

  // Stage 4: cofactor sums
  always_ff @(posedge clk) begin
    if (en) begin
      den   <= tpi_pkg::det_t'(t[0]) - tpi_pkg::det_t'(t[1]) + tpi_pkg::det_t'(t[2]);
      num_x <= tpi_pkg::det_t'(t[3]) + tpi_pkg::det_t'(t[4]) - tpi_pkg::det_t'(t[5]);
      num_y <= tpi_pkg::det_t'(t[8]) - tpi_pkg::det_t'(t[6]) - tpi_pkg::det_t'(t[7]);
      num_z <= tpi_pkg::det_t'(t[9]) - tpi_pkg::det_t'(t[10]) + tpi_pkg::det_t'(t[11]);
    end
  end
endmodule
`default_nettype wire

/* hdl/tpi_div.sv */
// Pipelined restoring divider lane: num * 2^OUT_FRAC_BITS / den, saturated.
// One quotient bit per step stage. Depends on tpi_pkg.
`default_nettype none
module tpi_div (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire tpi_pkg::det_t                   num,
  input  wire tpi_pkg::det_t                   den,
  output logic [tpi_pkg::OUT_WIDTH-1:0]        coord,
  output logic                                 over
);
  localparam int OW = tpi_pkg::OUT_WIDTH;

  logic [tpi_pkg::DET_W-1:0] mag_n, mag_d;
  logic                      neg;
  tpi_pkg::div_stage_t       first;
  tpi_pkg::div_stage_t       st [tpi_pkg::DIV_STEPS];
  logic [OW-1:0]             lim;
  logic                      ov_all;
  logic [OW-1:0]             val;

  // Take magnitudes and the result sign
  always_ff @(posedge clk) begin
    if (en) begin
      mag_n <= num[tpi_pkg::DET_W-1] ? -num : num;
      mag_d <= den[tpi_pkg::DET_W-1] ? -den : den;
      neg   <= num[tpi_pkg::DET_W-1] ^ den[tpi_pkg::DET_W-1];
    end
  end

  // Seed the remainder with the high numerator part; overflow if it already fits d
  always_comb begin
    first.rem  = tpi_pkg::REM_W'(mag_n >> tpi_pkg::SHIFT_IN);
    first.quo  = '0;
    first.bits = OW'({mag_n, {tpi_pkg::OUT_FRAC_BITS{1'b0}}});
    first.dmag = mag_d;
    first.neg  = neg;
    first.ov   = tpi_pkg::REM_W'(mag_n >> tpi_pkg::SHIFT_IN) >= tpi_pkg::REM_W'(mag_d);
  end

  // Advance one quotient bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= tpi_pkg::div_step(first);
      for (int i = 1; i < tpi_pkg::DIV_STEPS; i++) begin
        st[i] <= tpi_pkg::div_step(st[i-1]);
      end
    end
  end

  // Clip to the signed range and apply the sign
  always_comb begin
    lim    = st[tpi_pkg::DIV_STEPS-1].neg ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
    ov_all = st[tpi_pkg::DIV_STEPS-1].ov || (st[tpi_pkg::DIV_STEPS-1].quo > lim);
    val    = ov_all ? lim : st[tpi_pkg::DIV_STEPS-1].quo;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coord <= st[tpi_pkg::DIV_STEPS-1].neg ? -val : val;
      over  <= ov_all;
    end
  end
endmodule
`default_nettype wire

/* tb/three_plane_intersection_core_test.sv */
// Testbench for three_plane_intersection_core: random and directed plane triples,
// expected points computed by an exact Cramer's-rule solver in the testbench.
// Depends on the RTL of three_plane_intersection_core only.
`default_nettype none
module three_plane_intersection_core_test;
  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;

  // One plane triple: twelve signed Q8.8 coefficients, low field first.
  typedef logic signed [15:0] coef_t;
  typedef struct {
    logic        found;
    logic        saturated;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } point_t;

  logic [191:0] pending_words[$];
  point_t       expected_points[$];
  int           errors = 0;
  int           quiet_cycles = 0;
  bit           input_done = 0;
  bit           calm = 0;
  bit           hold_sink = 0;
  int           src_gap = 0;
  int           sink_gap = 0;

  three_plane_intersection_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  function automatic longint det3(longint a0, longint a1, longint a2,
                                  longint b0, longint b1, longint b2,
                                  longint c0, longint c1, longint c2);
    return a0 * (b1 * c2 - b2 * c1) - a1 * (b0 * c2 - b2 * c0)
         + a2 * (b0 * c1 - b1 * c0);
  endfunction

  // Scale num/den by 2^16, truncate toward zero, clip to 32 bits.
  function automatic logic [31:0] scaled_quotient(longint num, longint den,
                                                  inout logic sat);
    logic         neg;
    logic [63:0]  n;
    logic [63:0]  d;
    logic [63:0]  q;
    logic [63:0]  r;
    logic [63:0]  lim;
    logic         over;
    neg = (num < 0) != (den < 0);
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    q = n / d;
    r = n % d;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    over = q > lim;
    for (int i = 0; i < 16 && !over; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
      if (q > lim) over = 1'b1;
    end
    if (over) begin
      sat = 1'b1;
      q = lim;
    end
    if (neg) q = -q;
    return q[31:0];
  endfunction

  function automatic point_t solve_planes(logic [191:0] w);
    longint c[12];
    longint den;
    point_t p;
    logic   sat;
    for (int i = 0; i < 12; i++) c[i] = coef_t'(w[16*i +: 16]);
    den = det3(c[0], c[1], c[2], c[4], c[5], c[6], c[8], c[9], c[10]);
    p = '{1'b0, 1'b0, 32'd0, 32'd0, 32'd0};
    if (den == 0) return p;
    sat = 1'b0;
    p.px = scaled_quotient(det3(c[3], c[1], c[2], c[7], c[5], c[6], c[11], c[9], c[10]),
                           den, sat);
    p.py = scaled_quotient(det3(c[0], c[3], c[2], c[4], c[7], c[6], c[8], c[11], c[10]),
                           den, sat);
    p.pz = scaled_quotient(det3(c[0], c[1], c[3], c[4], c[5], c[7], c[8], c[9], c[11]),
                           den, sat);
    p.found = 1'b1;
    p.saturated = sat;
    return p;
  endfunction

  function automatic logic [15:0] rand_coef(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 8)) << $urandom_range(0, 12);
      2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default: return 16'($signed($urandom_range(0, 1024)) - 512);
    endcase
  endfunction

  function automatic logic [191:0] make_word(int mode);
    logic [191:0] w;
    for (int i = 0; i < 12; i++) w[16*i +: 16] = rand_coef(mode);
    // Mode 1 sometimes copies the normals of plane a into plane b, giving a singular triple
    if (mode == 1 && $urandom_range(0, 3) == 0) begin
      w[16*4 +: 16] = w[16*0 +: 16];
      w[16*5 +: 16] = w[16*1 +: 16];
      w[16*6 +: 16] = w[16*2 +: 16];
    end
    return w;
  endfunction

  // Stimulus: directed triples, then random ones
  initial begin
    logic [191:0] w;
    // identity normals with extreme offsets
    w = '0;
    w[0 +: 16] = 16'h0100; w[16*5 +: 16] = 16'h0100; w[16*10 +: 16] = 16'h0100;
    w[16*3 +: 16] = 16'h7FFF; w[16*7 +: 16] = 16'h8000; w[16*11 +: 16] = 16'h0000;
    pending_words.push_back(w);
    // unit determinant: x near the top of the range, y at its most negative value
    w = '0;
    w[0 +: 16] = 16'h0001; w[16*5 +: 16] = 16'h0001; w[16*10 +: 16] = 16'h0001;
    w[16*3 +: 16] = 16'h7FFF; w[16*7 +: 16] = 16'h8000; w[16*11 +: 16] = 16'h0001;
    pending_words.push_back(w);
    pending_words.push_back('0);              // singular, all zero
    pending_words.push_back({192{1'b1}});     // singular, all -1 LSB
    pending_words.push_back({12{16'h8000}});  // singular, most negative
    pending_words.push_back({12{16'h7FFF}});  // singular, most positive
    // extreme diagonals
    w = '0;
    w[0 +: 16] = 16'h8000; w[16*5 +: 16] = 16'h7FFF; w[16*10 +: 16] = 16'h8000;
    w[16*3 +: 16] = 16'h8000; w[16*7 +: 16] = 16'h7FFF; w[16*11 +: 16] = 16'hFFFF;
    pending_words.push_back(w);
    w[16*10 +: 16] = 16'h0001;
    pending_words.push_back(w);
    for (int i = 0; i < 12; i++) pending_words.push_back(make_word(i % 4));
    for (int i = 0; i < 1350; i++) pending_words.push_back(make_word($urandom_range(0, 3)));
  end

  // Reset, then a long receiver hold-off, then a calm final stretch
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (200) @(posedge clk);
    hold_sink <= 1'b1;
    repeat (150) @(posedge clk);
    hold_sink <= 1'b0;
    wait (pending_words.size() < 150);
    calm <= 1'b1;
  end

  // Driver: offer the next word, idle in random bursts
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) void'(pending_words.pop_front());
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        s_tvalid <= 1'b0;
      end else if ((!s_tvalid || s_tready) && !calm && $urandom_range(0, 15) == 0) begin
        src_gap <= $urandom_range(0, 18);
        s_tvalid <= 1'b0;
      end else if (pending_words.size() > ((s_tvalid && s_tready) ? 0 : 0) &&
                   !(s_tvalid && s_tready && pending_words.size() == 0)) begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_words[0];
      end else begin
        s_tvalid <= 1'b0;
        if (pending_words.size() == 0) input_done <= 1'b1;
      end
    end
  end

  // Record the expected point for every accepted word
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) expected_points.push_back(solve_planes(s_tdata));
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (!rst) begin
      if (hold_sink) begin
        m_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        sink_gap <= $urandom_range(0, 18);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    point_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_points.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, m_tdata);
        errors <= errors + 1;
      end else begin
        e = expected_points.pop_front();
        if (m_tdata[0] !== e.found || m_tdata[1] !== e.saturated ||
            m_tdata[33:2] !== e.px || m_tdata[65:34] !== e.py ||
            m_tdata[97:66] !== e.pz || m_tdata[103:98] !== 6'd0) begin
          $display("%0t mismatch: expected found=%b sat=%b x=%h y=%h z=%h, actual %h",
                   $time, e.found, e.saturated, e.px, e.py, e.pz, m_tdata);
          errors <= errors + 1;
        end
      end
    end
  end

  // Watchdog and end of run
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 2000) begin
      $display("status: fail");
      $finish;
    end else if (input_done && expected_points.size() == 0 && quiet_cycles > 60) begin
      if (errors == 0 && !m_tvalid) $display("status: pass");
      else $display("status: fail");
      $finish;
    end
  end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+hdl
hdl/tpi_pkg.sv
hdl/tpi_det.sv
hdl/tpi_div.sv
hdl/three_plane_intersection_core.sv
tb/three_plane_intersection_core_test.sv
